### hw/rtl/assert_macros.svh
// assertion macros used by the policy core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define SSBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SSBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ssbp_pkg.sv
// types, constants and set row layout for the ship/srrip stream bypass policy
`timescale 1ns / 1ps
`default_nettype none
package ssbp_pkg;

  localparam int NUM_SETS     = 2048;
  localparam int NUM_WAYS     = 16;
  localparam int SIGS_PER_SET = 4;
  localparam int SIG_WIDTH    = 6;

  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int SIG_IDX_W = $clog2(SIGS_PER_SET);
  localparam int ADDR_W    = 48;
  localparam int STRIDE_W  = 16;

  // ways examined per cycle by the victim scan
  localparam int LANES      = 4;
  localparam int LANE_W     = $clog2(LANES);
  localparam int SCAN_STEPS = NUM_WAYS / LANES;
  localparam int STEP_W     = $clog2(SCAN_STEPS);

  localparam logic [1:0] RRPV_MAX     = 2'd3;
  localparam logic [1:0] RRPV_NEAR    = 2'd0;
  localparam logic [1:0] RRPV_FAR     = 2'd2;
  localparam logic [1:0] CTR_MAX      = 2'd3;
  localparam logic [1:0] OUTCOME_INIT = 2'd1;
  localparam logic [1:0] OUTCOME_HIGH = 2'd2;

  localparam logic [STRIDE_W-1:0] STRIDE_MIN_RST = 16'd64;
  localparam logic [STRIDE_W-1:0] STRIDE_MAX_RST = 16'd4096;

  // configuration register indexes
  localparam logic CFG_STRIDE_MIN = 1'b0;
  localparam logic CFG_STRIDE_MAX = 1'b1;

  typedef struct packed {
    logic [10:0] set_index;
    logic [47:0] line_address;
    logic [5:0]  pc_signature;
    logic        hit;
    logic [3:0]  hit_way;
    logic        victim_valid;
  } req_t;

  typedef struct packed {
    logic       bypass;
    logic [3:0] way_used;
  } rsp_t;

  // everything the policy keeps for one set, held as one memory row
  typedef struct packed {
    logic [ADDR_W-1:0]                         prev_addr;
    logic [1:0]                                stream_cnt;
    logic [SIG_IDX_W-1:0]                      refill_ptr;
    logic [SIGS_PER_SET-1:0][1:0]              outcome;
    logic [SIGS_PER_SET-1:0][SIG_WIDTH-1:0]    sig;
    logic [NUM_WAYS-1:0][1:0]                  rrpv;
  } set_row_t;

  localparam int ROW_W = $bits(set_row_t);

  localparam set_row_t ROW_RESET = '{
    prev_addr:  '0,
    stream_cnt: '0,
    refill_ptr: '0,
    outcome:    {SIGS_PER_SET{OUTCOME_INIT}},
    sig:        '0,
    rrpv:       {NUM_WAYS{RRPV_MAX}}
  };

endpackage
`default_nettype wire

### hw/rtl/ship_srrip_stream_bypass_policy_core.sv
// top level: stream detector, srrip victim scan and signature outcome update
//
//  channel   direction  handshake                   payload
//  req       in         req_valid_i / req_ready_o   req_i  (req_t)
//  rsp       out        rsp_valid_o / rsp_ready_i   rsp_o  (rsp_t)
//  cfg       in         cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
//  a request passes through the set row read, the stride check, the victim scan
//  (LANES ways a cycle, misses only), the row update (skipped when bypassed)
//  and the write back.
//  after reset a clearing pass writes every set row while ready is low.
//  a stalled response holds the write-back state until the response register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ship_srrip_stream_bypass_policy_core
  import ssbp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  output logic                     req_ready_o,
  input  wire req_t                req_i,
  output logic                     rsp_valid_o,
  input  wire logic                rsp_ready_i,
  output rsp_t                     rsp_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [STRIDE_W-1:0] cfg_wdata_i
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOOK   = 6'b000010,
    S_STREAM = 6'b000100,
    S_SCAN   = 6'b001000,
    S_UPD    = 6'b010000,
    S_WRITE  = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic                     clr_q;
  logic [SET_W-1:0]         clr_cnt_q;
  logic [STRIDE_W-1:0]      stride_min_q, stride_max_q;
  req_t                     req_q;
  set_row_t                 row_q;
  set_row_t                 row_upd;
  set_row_t                 ram_rdata;
  logic [ADDR_W-1:0]        stride_q;
  logic [NUM_WAYS-1:0][1:0] scan_q;
  logic [1:0]               top_q, top_nxt;
  logic [WAY_W-1:0]         best_q, best_nxt;
  logic [STEP_W-1:0]        step_q;
  logic [WAY_W-1:0]         way_q;
  logic                     bypass_q;
  rsp_t                     rsp_q;
  logic                     rsp_valid_q;

  logic                     accept;
  logic                     wb_go;
  logic                     ram_we;
  logic [SET_W-1:0]         ram_waddr;
  set_row_t                 ram_wdata;

  logic                     in_range;
  logic [1:0]               cnt_new;

  logic                     sig_found;
  logic [SIG_IDX_W-1:0]     sig_idx;
  logic [1:0]               o_cur, o_dec, o_new;
  logic [1:0]               age_add;
  logic [1:0]               ins_rrpv;
  logic [SIG_WIDTH-1:0]     sig_in;

  assign req_ready_o = (state_q == S_IDLE) && !clr_q;
  assign accept      = req_valid_i && req_ready_o;
  assign wb_go       = (state_q == S_WRITE) && (!rsp_valid_q || rsp_ready_i);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // clearing pass owns the write port until done
  assign ram_we    = clr_q || wb_go;
  assign ram_waddr = clr_q ? clr_cnt_q : req_q.set_index[SET_W-1:0];
  assign ram_wdata = clr_q ? ROW_RESET : row_q;

  ssbp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (req_i.set_index[SET_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // stride check, upper bits must be clear to fall inside a 16 bit window
  always_comb begin
    in_range = (stride_q[ADDR_W-1:STRIDE_W] == '0)
            && (stride_q[STRIDE_W-1:0] >= stride_min_q)
            && (stride_q[STRIDE_W-1:0] <= stride_max_q);
    if (in_range) begin
      cnt_new = (row_q.stream_cnt == CTR_MAX) ? CTR_MAX : row_q.stream_cnt + 2'd1;
    end else begin
      cnt_new = (row_q.stream_cnt == 2'd0) ? 2'd0 : row_q.stream_cnt - 2'd1;
    end
  end

  // victim scan: LANES ways a step, lowest way with the highest rrpv wins
  always_comb begin
    top_nxt  = top_q;
    best_nxt = best_q;
    for (int l = 0; l < LANES; l++) begin
      if (scan_q[l] > top_nxt) begin
        top_nxt  = scan_q[l];
        best_nxt = {step_q, LANE_W'(l)};
      end
    end
  end

  // signature lookup, aging and outcome update on the working row
  always_comb begin
    sig_in    = req_q.pc_signature[SIG_WIDTH-1:0];
    sig_found = 1'b0;
    sig_idx   = row_q.refill_ptr;
    for (int i = SIGS_PER_SET - 1; i >= 0; i--) begin
      if (row_q.sig[i] == sig_in) begin
        sig_found = 1'b1;
        sig_idx   = SIG_IDX_W'(i);
      end
    end
    o_cur   = sig_found ? row_q.outcome[sig_idx] : OUTCOME_INIT;
    o_dec   = (o_cur == 2'd0) ? 2'd0 : o_cur - 2'd1;
    age_add = RRPV_MAX - top_q;

    if (req_q.hit) begin
      o_new    = (o_cur == CTR_MAX) ? CTR_MAX : o_cur + 2'd1;
      ins_rrpv = RRPV_NEAR;
    end else begin
      o_new    = (req_q.victim_valid && o_dec != 2'd0) ? o_dec - 2'd1 : o_dec;
      ins_rrpv = (o_cur >= OUTCOME_HIGH) ? RRPV_NEAR : RRPV_FAR;
    end

    row_upd = row_q;
    if (!sig_found) begin
      row_upd.sig[sig_idx] = sig_in;
      row_upd.refill_ptr   = sig_idx + SIG_IDX_W'(1);
    end
    row_upd.outcome[sig_idx] = o_new;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WAY_W'(w) == way_q) begin
        row_upd.rrpv[w] = ins_rrpv;
      end else begin
        row_upd.rrpv[w] = row_q.rrpv[w] + age_add;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_LOOK;
      S_LOOK:   state_d = S_STREAM;
      S_STREAM: begin
        if (!req_q.hit && cnt_new == CTR_MAX) begin
          state_d = S_WRITE;
        end else if (req_q.hit) begin
          state_d = S_UPD;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN:   if (step_q == STEP_W'(SCAN_STEPS - 1)) state_d = S_UPD;
      S_UPD:    state_d = S_WRITE;
      S_WRITE:  if (wb_go) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      clr_q        <= 1'b1;
      clr_cnt_q    <= '0;
      stride_min_q <= STRIDE_MIN_RST;
      stride_max_q <= STRIDE_MAX_RST;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + SET_W'(1);
        if (clr_cnt_q == SET_W'(NUM_SETS - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STRIDE_MIN: stride_min_q <= cfg_wdata_i;
          CFG_STRIDE_MAX: stride_max_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (wb_go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) req_q <= req_i;
      end
      S_LOOK: begin
        row_q    <= ram_rdata;
        stride_q <= req_q.line_address - ram_rdata.prev_addr;
      end
      S_STREAM: begin
        row_q.stream_cnt <= cnt_new;
        row_q.prev_addr  <= req_q.line_address;
        scan_q           <= row_q.rrpv;
        step_q           <= '0;
        best_q           <= '0;
        if (!req_q.hit && cnt_new == CTR_MAX) begin
          bypass_q <= 1'b1;
          way_q    <= '0;
        end else begin
          bypass_q <= 1'b0;
          way_q    <= req_q.hit_way[WAY_W-1:0];
          // a hit ages nothing
          top_q    <= req_q.hit ? RRPV_MAX : 2'd0;
        end
      end
      S_SCAN: begin
        top_q  <= top_nxt;
        best_q <= best_nxt;
        scan_q <= scan_q >> (2 * LANES);
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(SCAN_STEPS - 1)) begin
          way_q <= best_nxt;
        end
      end
      S_UPD: begin
        row_q <= row_upd;
      end
      S_WRITE: begin
        if (wb_go) begin
          rsp_q.bypass   <= bypass_q;
          rsp_q.way_used <= 4'(way_q);
        end
      end
      default: ;
    endcase
  end

  `SSBP_ASSERT(a_no_req_while_clearing, !(req_ready_o && clr_q),
    "request accepted during clearing pass")
  `SSBP_ASSERT(a_bypass_way_zero, !(rsp_valid_o && rsp_o.bypass) || rsp_o.way_used == 4'd0,
    "bypassed response carries a way")
  `SSBP_ASSERT_NEXT(a_accept_reads_row, req_valid_i && req_ready_o, state_q == S_LOOK,
    "accepted request did not start the row read")
  `SSBP_ASSERT_NEXT(a_writeback_gives_rsp, wb_go, rsp_valid_o && state_q == S_IDLE,
    "row write back without a response")

endmodule
`default_nettype wire

### hw/rtl/ssbp_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module ssbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### verif/tb.sv
// self-checking testbench for the ship/srrip stream bypass replacement policy core
`timescale 1ns / 1ps
module tb;
  import ssbp_pkg::*;

  localparam int WATCHDOG_LIMIT  = 12000;
  localparam int DRAIN_CYCLES    = 16;
  localparam int RANDOM_ACCESSES = 1130;
  localparam int SET_POOL        = 8;
  localparam int NUM_WINDOWS     = 6;

  // mirror of the policy state, one expected response per accepted request
  class choice_checker;
    logic [1:0]           rrpv_age   [NUM_SETS][NUM_WAYS];
    logic [SIG_WIDTH-1:0] sig_tag    [NUM_SETS][SIGS_PER_SET];
    logic [1:0]           outcome    [NUM_SETS][SIGS_PER_SET];
    logic [SIG_IDX_W-1:0] refill_at  [NUM_SETS];
    logic [1:0]           stream_cnt [NUM_SETS];
    logic [ADDR_W-1:0]    prev_line  [NUM_SETS];
    logic [STRIDE_W-1:0]  stride_lo;
    logic [STRIDE_W-1:0]  stride_hi;
    rsp_t                 expected_choices [$];
    int                   mismatches;
    int                   checked;
    int                   hits;
    int                   fills;
    int                   bypasses;

    function new();
      int s, i;
      stride_lo = STRIDE_MIN_RST;
      stride_hi = STRIDE_MAX_RST;
      for (s = 0; s < NUM_SETS; s++) begin
        for (i = 0; i < NUM_WAYS; i++) rrpv_age[s][i] = RRPV_MAX;
        for (i = 0; i < SIGS_PER_SET; i++) begin
          sig_tag[s][i] = '0;
          outcome[s][i] = OUTCOME_INIT;
        end
        refill_at[s]  = '0;
        stream_cnt[s] = '0;
        prev_line[s]  = '0;
      end
      mismatches = 0;
      checked    = 0;
      hits       = 0;
      fills      = 0;
      bypasses   = 0;
    endfunction

    function void note_access(req_t a);
      int s, w, e, i;
      logic [ADDR_W-1:0] stride;
      logic [1:0] top;
      rsp_t r;
      s = int'(a.set_index) % NUM_SETS;
      // stride taken modulo the address width
      stride = a.line_address - prev_line[s];
      prev_line[s] = a.line_address;
      if (stride >= ADDR_W'(stride_lo) && stride <= ADDR_W'(stride_hi)) begin
        if (stream_cnt[s] != CTR_MAX) stream_cnt[s] = stream_cnt[s] + 2'd1;
      end else if (stream_cnt[s] != 2'd0) begin
        stream_cnt[s] = stream_cnt[s] - 2'd1;
      end
      r = '0;
      if (!a.hit && stream_cnt[s] == CTR_MAX) begin
        r.bypass = 1'b1;
        bypasses++;
      end else begin
        if (a.hit) begin
          w = int'(a.hit_way) % NUM_WAYS;
        end else begin
          // lowest way with the oldest rrpv, then age the whole set up to the max
          top = 2'd0;
          w = 0;
          for (i = 0; i < NUM_WAYS; i++) begin
            if (rrpv_age[s][i] > top) begin
              top = rrpv_age[s][i];
              w = i;
            end
          end
          if (top != RRPV_MAX) begin
            for (i = 0; i < NUM_WAYS; i++) rrpv_age[s][i] = rrpv_age[s][i] + (RRPV_MAX - top);
          end
        end
        e = -1;
        for (i = 0; i < SIGS_PER_SET; i++) begin
          if (e < 0 && sig_tag[s][i] == a.pc_signature[SIG_WIDTH-1:0]) e = i;
        end
        if (e < 0) begin
          e = int'(refill_at[s]) % SIGS_PER_SET;
          sig_tag[s][e] = a.pc_signature[SIG_WIDTH-1:0];
          outcome[s][e] = OUTCOME_INIT;
          refill_at[s] = SIG_IDX_W'((e + 1) % SIGS_PER_SET);
        end
        if (a.hit) begin
          rrpv_age[s][w] = RRPV_NEAR;
          if (outcome[s][e] != CTR_MAX) outcome[s][e] = outcome[s][e] + 2'd1;
          hits++;
        end else begin
          rrpv_age[s][w] = (outcome[s][e] >= OUTCOME_HIGH) ? RRPV_NEAR : RRPV_FAR;
          if (outcome[s][e] != 2'd0) outcome[s][e] = outcome[s][e] - 2'd1;
          if (a.victim_valid && outcome[s][e] != 2'd0) outcome[s][e] = outcome[s][e] - 2'd1;
          fills++;
        end
        r.way_used = WAY_W'(w);
      end
      expected_choices.push_back(r);
    endfunction

    function void report(string what, logic [3:0] want, logic [3:0] got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    function void check_choice(rsp_t got);
      rsp_t want;
      checked++;
      if (expected_choices.size() == 0) begin
        report("unrequested response, way_used", 4'h0, got.way_used);
      end else begin
        want = expected_choices.pop_front();
        if (got.bypass !== want.bypass) report("bypass", want.bypass, got.bypass);
        if (got.way_used !== want.way_used) report("way_used", want.way_used, got.way_used);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                req_valid;
  logic                req_ready;
  req_t                req_bus;
  logic                rsp_valid;
  logic                rsp_ready;
  rsp_t                rsp_bus;
  logic                cfg_we;
  logic                cfg_idx;
  logic [STRIDE_W-1:0] cfg_wdata;

  choice_checker       sb = new();
  int                  idle_cycles = 0;
  int                  burst_left = 0;
  int                  sent = 0;
  logic [SET_W-1:0]    pool_set  [SET_POOL];
  logic [ADDR_W-1:0]   walk_addr [SET_POOL];

  ship_srrip_stream_bypass_policy_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req_bus),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // monitor and idle counter, both sampled at the edge
  always @(posedge clk_i) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_ni) begin
      if (req_valid && req_ready) sb.note_access(req_bus);
      if (rsp_valid && rsp_ready) sb.check_choice(rsp_bus);
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // response side backpressure, its pattern changing from one random span to the next
  initial begin : sink_pacing
    int mode, span;
    rsp_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= ($urandom_range(0, 1) == 1);
          2: rsp_ready <= ($urandom_range(0, 7) == 0);
          default: rsp_ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  function automatic req_t access(input logic [SET_W-1:0] set_idx, input logic [ADDR_W-1:0] addr,
                                  input logic [5:0] sig, input logic hit, input logic [3:0] way,
                                  input logic victim_valid);
    req_t a;
    a.set_index    = set_idx;
    a.line_address = addr;
    a.pc_signature = sig;
    a.hit          = hit;
    a.hit_way      = way;
    a.victim_valid = victim_valid;
    return a;
  endfunction

  // small pool of signatures so lookups both match and refill
  function automatic logic [5:0] pick_sig();
    if ($urandom_range(0, 4) == 0) return 6'($urandom);
    return 6'($urandom_range(0, 5)) ^ (($urandom_range(0, 1) == 1) ? 6'h3F : 6'h00);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_stride();
    logic [STRIDE_W-1:0] lo, hi;
    lo = sb.stride_lo;
    hi = sb.stride_hi;
    if (lo > hi) return ADDR_W'($urandom_range(0, 70000));
    case ($urandom_range(0, 9))
      0: return ADDR_W'(lo);
      1: return ADDR_W'(hi);
      2: return ADDR_W'(lo) - 48'd1;
      3: return ADDR_W'(hi) + 48'd1;
      default: return ADDR_W'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic send_access(input req_t a);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req_bus   <= a;
    do @(posedge clk_i); while (!req_ready);
    sent++;
  endtask

  // wait until every request has been answered and the block has gone quiet
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_choices.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_stride_window(input logic [STRIDE_W-1:0] lo, input logic [STRIDE_W-1:0] hi);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_STRIDE_MIN;
    cfg_wdata <= lo;
    @(posedge clk_i);
    sb.stride_lo = lo;
    cfg_idx   <= CFG_STRIDE_MAX;
    cfg_wdata <= hi;
    @(posedge clk_i);
    sb.stride_hi = hi;
    cfg_we    <= 1'b0;
  endtask

  // mostly misses on strides mostly inside the stride window so the set falls into streaming
  task automatic stream_run(input int p, input int n);
    repeat (n) begin
      walk_addr[p] = walk_addr[p] + pick_stride();
      send_access(access(pool_set[p], walk_addr[p], pick_sig(), $urandom_range(0, 4) == 0,
                         4'($urandom), 1'($urandom)));
    end
  endtask

  // irregular strides, mostly hits
  task automatic reuse_run(input int p, input int n);
    repeat (n) begin
      walk_addr[p] = walk_addr[p] + ADDR_W'($urandom_range(0, 8192));
      send_access(access(pool_set[p], walk_addr[p], pick_sig(), $urandom_range(0, 4) < 3,
                         4'($urandom), 1'($urandom)));
    end
  endtask

  initial begin : stimulus
    int ph, p, pick, phase_end, k;
    rst_ni    = 1'b0;
    req_valid = 1'b0;
    req_bus   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_STRIDE_MIN;
    cfg_wdata = '0;
    pool_set[0] = '0;
    pool_set[1] = '1;
    pool_set[2] = 11'd1;
    pool_set[3] = 11'd1024;
    for (k = 4; k < SET_POOL; k++) pool_set[k] = 11'($urandom);
    for (k = 0; k < SET_POOL; k++) walk_addr[k] = {16'($urandom), $urandom};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes
    send_access(access(11'd0, 48'd0, 6'd0, 1'b0, 4'd0, 1'b0));
    send_access(access(11'd2047, 48'hFFFF_FFFF_FFFF, 6'd63, 1'b1, 4'd15, 1'b1));
    send_access(access(11'd2047, 48'hFFFF_FFFF_FFFF, 6'd63, 1'b0, 4'd0, 1'b1));
    // strides at both bounds build a stream, then a bypassed miss and a hit while streaming
    send_access(access(11'd5, 48'd64, 6'd7, 1'b0, 4'd0, 1'b0));
    send_access(access(11'd5, 48'd4160, 6'd7, 1'b0, 4'd0, 1'b0));
    send_access(access(11'd5, 48'd4260, 6'd7, 1'b0, 4'd9, 1'b1));
    send_access(access(11'd5, 48'd4360, 6'd7, 1'b1, 4'd7, 1'b0));
    send_access(access(11'd5, 48'd4423, 6'd7, 1'b0, 4'd0, 1'b1));
    send_access(access(11'd5, 48'd8520, 6'd7, 1'b0, 4'd0, 1'b0));
    // five signatures in one set wrap the refill pointer
    for (k = 1; k <= 5; k++) begin
      send_access(access(11'd9, ADDR_W'(k) << 20, 6'(k), 1'b0, 4'd0, 1'(k)));
    end
    send_access(access(11'd9, 48'd6 << 20, 6'd1, 1'b0, 4'd0, 1'b1));
    // trained signature inserts near
    send_access(access(11'd9, 48'd7 << 20, 6'd5, 1'b1, 4'd3, 1'b0));
    send_access(access(11'd9, 48'd8 << 20, 6'd5, 1'b1, 4'd3, 1'b0));
    send_access(access(11'd9, 48'd9 << 20, 6'd5, 1'b0, 4'd0, 1'b0));
    // stride that wraps past the top of the address space
    send_access(access(11'd12, 48'hFFFF_FFFF_FFC0, 6'd2, 1'b0, 4'd0, 1'b0));
    send_access(access(11'd12, 48'h0000_0000_0040, 6'd2, 1'b0, 4'd0, 1'b0));

    for (ph = 0; ph < NUM_WINDOWS; ph++) begin
      case (ph)
        1: set_stride_window(16'd0, 16'hFFFF);
        2: set_stride_window(16'hFFFF, 16'd0);   // crossed bounds, no set streams
        3: set_stride_window(16'd128, 16'd128);
        4: set_stride_window(16'd16, 16'd1024);
        5: set_stride_window(STRIDE_MIN_RST, STRIDE_MAX_RST);
        default: ;
      endcase
      phase_end = sent + RANDOM_ACCESSES / NUM_WINDOWS;
      while (sent < phase_end) begin
        p    = $urandom_range(0, SET_POOL - 1);
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          stream_run(p, $urandom_range(3, 10));
        end else if (pick < 16) begin
          reuse_run(p, $urandom_range(2, 8));
        end else begin
          repeat ($urandom_range(1, 3)) begin
            send_access(access(11'($urandom), {16'($urandom), $urandom}, 6'($urandom),
                               1'($urandom), 4'($urandom), 1'($urandom)));
          end
        end
      end
    end

    settle();
    $display("%0d requests over %0d stride windows: %0d hits, %0d fills, %0d bypassed misses",
             sent, NUM_WINDOWS, sb.hits, sb.fills, sb.bypasses);
    $display("%0d responses checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_choices.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ssbp_pkg.sv
hw/rtl/ssbp_ram.sv
hw/rtl/ship_srrip_stream_bypass_policy_core.sv
verif/tb.sv
